FILE: rtl/lbm_pkg.sv
// ============================================================================
// lbm_pkg
// Shared types and constants of the buffer manager: request modes, result
// codes, controller states and the control/status links between its parts.
// ============================================================================
package lbm_pkg;

    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int CNT_W   = 8;
    localparam int IDX_W   = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_GET     = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_PIN     = 2'd2,
        MODE_UNPIN   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_COUNT_ERR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUTE,
        S_SCAN,
        S_SCAN_END,
        S_GET_COMMIT,
        S_BI_CHECK,
        S_PASS,
        S_PASS_END,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic rd_scan;
        logic rd_sel;
        logic acc_scan;
        logic commit_get;
        logic commit_bi;
        logic wr_pass;
        logic echo;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_get;
        logic in_range;
        logic cnt_last;
        logic need_pass;
    } t_dp_sts;

endpackage

FILE: rtl/lbm_ctrl.sv
// ============================================================================
// lbm_ctrl
// Sequencer of the buffer manager: steps the datapath through tag scans,
// count updates and rank passes, and runs both handshakes.
// ============================================================================
module lbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  lbm_pkg::t_dp_sts  i_sts,
    output lbm_pkg::t_dp_cmd  o_cmd
);

    lbm_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            lbm_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = lbm_pkg::S_ROUTE;
                end
            end
            lbm_pkg::S_ROUTE: begin
                if (i_sts.is_get) begin
                    n_state = lbm_pkg::S_SCAN;
                end else if (!i_sts.in_range) begin
                    o_cmd.echo = 1'b1;
                    n_state    = lbm_pkg::S_DONE;
                end else begin
                    o_cmd.rd_sel = 1'b1;
                    n_state      = lbm_pkg::S_BI_CHECK;
                end
            end
            lbm_pkg::S_SCAN: begin
                o_cmd.rd_scan  = 1'b1;
                o_cmd.acc_scan = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = lbm_pkg::S_SCAN_END;
                end
            end
            lbm_pkg::S_SCAN_END: begin
                o_cmd.acc_scan = 1'b1;
                n_state        = lbm_pkg::S_GET_COMMIT;
            end
            lbm_pkg::S_GET_COMMIT: begin
                o_cmd.commit_get = 1'b1;
                n_state          = lbm_pkg::S_DONE;
            end
            lbm_pkg::S_BI_CHECK: begin
                o_cmd.commit_bi = 1'b1;
                o_cmd.cnt_clr   = 1'b1;
                n_state = i_sts.need_pass ? lbm_pkg::S_PASS : lbm_pkg::S_DONE;
            end
            lbm_pkg::S_PASS: begin
                o_cmd.rd_scan = 1'b1;
                o_cmd.wr_pass = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = lbm_pkg::S_PASS_END;
                end
            end
            lbm_pkg::S_PASS_END: begin
                o_cmd.wr_pass = 1'b1;
                n_state       = lbm_pkg::S_DONE;
            end
            lbm_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lbm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lbm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != lbm_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: rtl/lbm_dp.sv
// ============================================================================
// lbm_dp
// Datapath of the buffer manager: per-buffer tag/count/rank memory, scan
// counter, hit and victim trackers, result and output registers.
// ============================================================================
module lbm_dp #(
    parameter int BUFFER_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lbm_pkg::t_dp_cmd              i_cmd,
    output lbm_pkg::t_dp_sts              o_sts,
    input  logic [1:0]                    i_mode,
    input  logic [lbm_pkg::DEV_W-1:0]     i_device,
    input  logic [lbm_pkg::BLK_W-1:0]     i_block_number,
    input  logic [lbm_pkg::IDX_W-1:0]     i_buffer_index,
    output logic [lbm_pkg::IDX_W-1:0]     o_result_index,
    output logic                          o_hit,
    output logic                          o_fill_needed,
    output logic [1:0]                    o_status
);

    localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
    localparam int PW = lbm_pkg::IDX_W;
    localparam int DW = lbm_pkg::DEV_W;
    localparam int BW = lbm_pkg::BLK_W;
    localparam int CW = lbm_pkg::CNT_W;
    localparam logic [IW-1:0] LAST  = IW'(BUFFER_COUNT - 1);
    localparam logic [CW-1:0] CNT_1 = CW'(1);

    // buffer state memory
    logic [DW-1:0] mem_dev  [BUFFER_COUNT];
    logic [BW-1:0] mem_blk  [BUFFER_COUNT];
    logic          mem_cv   [BUFFER_COUNT];
    logic [CW-1:0] mem_cnt  [BUFFER_COUNT];
    logic [IW-1:0] mem_rank [BUFFER_COUNT];
    logic [BUFFER_COUNT-1:0] r_written;

    logic [DW-1:0] r_rd_dev_raw;
    logic [BW-1:0] r_rd_blk_raw;
    logic          r_rd_cv_raw;
    logic [CW-1:0] r_rd_cnt_raw;
    logic [IW-1:0] r_rd_rank_raw;
    logic          r_rd_wr;
    logic [IW-1:0] r_rd_addr;
    logic          r_rd_vld;

    logic [DW-1:0] rd_dev;
    logic [BW-1:0] rd_blk;
    logic          rd_cv;
    logic [CW-1:0] rd_count;
    logic [IW-1:0] rd_rank;
    logic [IW-1:0] rd_addr;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [DW-1:0] wr_dev;
    logic [BW-1:0] wr_blk;
    logic          wr_cv;
    logic [CW-1:0] wr_cnt;
    logic [IW-1:0] wr_rank;

    // request registers
    lbm_pkg::t_mode r_mode;
    logic [DW-1:0]  r_dev;
    logic [BW-1:0]  r_blk;
    logic [PW-1:0]  r_bi;
    logic [IW-1:0]  bi_idx;
    logic [IW-1:0]  r_cnt;

    // trackers
    logic          r_hit_found;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_hit_rank;
    logic [CW-1:0] r_hit_cnt;
    logic          r_hit_cv;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_free_rank;
    logic          match;
    logic          take_hit;
    logic          take_free;

    // result and output
    logic [PW-1:0]     r_res_idx, n_res_idx;
    logic              r_res_hit, n_res_hit;
    logic              r_res_fill, n_res_fill;
    lbm_pkg::t_status  r_res_status, n_res_status;
    logic [IW-1:0]     r_old_rank, n_old_rank;
    logic [PW-1:0]     r_out_idx;
    logic              r_out_hit;
    logic              r_out_fill;
    lbm_pkg::t_status  r_out_status;

    assign bi_idx  = IW'(r_bi);
    assign rd_addr = i_cmd.rd_sel ? bi_idx : r_cnt;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_dev[wr_addr]  <= wr_dev;
            mem_blk[wr_addr]  <= wr_blk;
            mem_cv[wr_addr]   <= wr_cv;
            mem_cnt[wr_addr]  <= wr_cnt;
            mem_rank[wr_addr] <= wr_rank;
        end
        r_rd_dev_raw  <= mem_dev[rd_addr];
        r_rd_blk_raw  <= mem_blk[rd_addr];
        r_rd_cv_raw   <= mem_cv[rd_addr];
        r_rd_cnt_raw  <= mem_cnt[rd_addr];
        r_rd_rank_raw <= mem_rank[rd_addr];
        r_rd_addr     <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_wr   <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_written[wr_addr] <= 1'b1;
            end
            r_rd_wr  <= r_written[rd_addr];
            r_rd_vld <= i_cmd.rd_scan | i_cmd.rd_sel;
        end
    end

    // unwritten entries read as their reset value
    assign rd_dev   = r_rd_wr ? r_rd_dev_raw  : '0;
    assign rd_blk   = r_rd_wr ? r_rd_blk_raw  : '0;
    assign rd_cv    = r_rd_wr ? r_rd_cv_raw   : 1'b0;
    assign rd_count = r_rd_wr ? r_rd_cnt_raw  : '0;
    assign rd_rank  = r_rd_wr ? r_rd_rank_raw : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= lbm_pkg::t_mode'(i_mode);
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_bi   <= i_buffer_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.rd_scan) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign match     = (rd_dev == r_dev) && (rd_blk == r_blk);
    assign take_hit  = match && (!r_hit_found || (rd_rank > r_hit_rank));
    assign take_free = (rd_count == '0) && (!r_free_found || (rd_rank < r_free_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.acc_scan && r_rd_vld) begin
            if (take_hit) begin
                r_hit_found <= 1'b1;
            end
            if (take_free) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_scan && r_rd_vld) begin
            if (take_hit) begin
                r_hit_idx  <= r_rd_addr;
                r_hit_rank <= rd_rank;
                r_hit_cnt  <= rd_count;
                r_hit_cv   <= rd_cv;
            end
            if (take_free) begin
                r_free_idx  <= r_rd_addr;
                r_free_rank <= rd_rank;
            end
        end
    end

    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = r_rd_addr;
        wr_dev       = rd_dev;
        wr_blk       = rd_blk;
        wr_cv        = rd_cv;
        wr_cnt       = rd_count;
        wr_rank      = rd_rank;
        n_res_idx    = r_res_idx;
        n_res_hit    = r_res_hit;
        n_res_fill   = r_res_fill;
        n_res_status = r_res_status;
        n_old_rank   = r_old_rank;
        if (i_cmd.commit_get) begin
            wr_dev = r_dev;
            wr_blk = r_blk;
            wr_cv  = 1'b1;
            if (r_hit_found) begin
                n_res_idx  = PW'(r_hit_idx);
                n_res_hit  = 1'b1;
                if (r_hit_cnt >= lbm_pkg::COUNT_MAX) begin
                    n_res_fill   = 1'b0;
                    n_res_status = lbm_pkg::ST_COUNT_ERR;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = r_hit_idx;
                    wr_cnt       = r_hit_cnt + 1'b1;
                    wr_rank      = r_hit_rank;
                    n_res_fill   = !r_hit_cv;
                    n_res_status = lbm_pkg::ST_OK;
                end
            end else if (r_free_found) begin
                wr_en        = 1'b1;
                wr_addr      = r_free_idx;
                wr_cnt       = CNT_1;
                wr_rank      = r_free_rank;
                n_res_idx    = PW'(r_free_idx);
                n_res_hit    = 1'b0;
                n_res_fill   = 1'b1;
                n_res_status = lbm_pkg::ST_OK;
            end else begin
                n_res_idx    = '0;
                n_res_hit    = 1'b0;
                n_res_fill   = 1'b0;
                n_res_status = lbm_pkg::ST_NO_FREE;
            end
        end else if (i_cmd.commit_bi) begin
            wr_addr      = bi_idx;
            n_res_idx    = r_bi;
            n_res_hit    = 1'b0;
            n_res_fill   = 1'b0;
            n_res_status = lbm_pkg::ST_OK;
            n_old_rank   = rd_rank;
            if (r_mode == lbm_pkg::MODE_PIN) begin
                if (rd_count >= lbm_pkg::COUNT_MAX) begin
                    n_res_status = lbm_pkg::ST_COUNT_ERR;
                end else begin
                    wr_en  = 1'b1;
                    wr_cnt = rd_count + 1'b1;
                end
            end else if (rd_count == '0) begin
                n_res_status = lbm_pkg::ST_COUNT_ERR;
            end else if (!o_sts.need_pass) begin
                wr_en  = 1'b1;
                wr_cnt = rd_count - 1'b1;
            end
        end else if (i_cmd.wr_pass && r_rd_vld) begin
            wr_en = 1'b1;
            if (r_rd_addr == bi_idx) begin
                wr_cnt  = '0;
                wr_rank = LAST;
            end else if (rd_rank > r_old_rank) begin
                wr_rank = rd_rank - 1'b1;
            end
        end else if (i_cmd.echo) begin
            n_res_idx    = r_bi;
            n_res_hit    = 1'b0;
            n_res_fill   = 1'b0;
            n_res_status = lbm_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_idx    <= n_res_idx;
        r_res_hit    <= n_res_hit;
        r_res_fill   <= n_res_fill;
        r_res_status <= n_res_status;
        r_old_rank   <= n_old_rank;
        if (i_cmd.out_load) begin
            r_out_idx    <= r_res_idx;
            r_out_hit    <= r_res_hit;
            r_out_fill   <= r_res_fill;
            r_out_status <= r_res_status;
        end
    end

    assign o_sts.is_get    = (r_mode == lbm_pkg::MODE_GET);
    assign o_sts.in_range  = (32'(r_bi) < 32'(BUFFER_COUNT));
    assign o_sts.cnt_last  = (r_cnt == LAST);
    assign o_sts.need_pass = (r_mode == lbm_pkg::MODE_RELEASE) && (rd_count == CNT_1);

    assign o_result_index = r_out_idx;
    assign o_hit          = r_out_hit;
    assign o_fill_needed  = r_out_fill;
    assign o_status       = r_out_status;

endmodule

FILE: rtl/lru_block_buffer_manager.sv
// a get scans every entry before it commits its result; a release that drops the count
// to zero also runs a rank pass over all entries; others read one entry, if in range
// one item in flight; the buffer state memory is scanned one entry per cycle
// reset: synchronous, clears control state and per-entry written marks;
// unwritten entries read as zero tags/counts and rank equal to index
// ============================================================================
// lru_block_buffer_manager
// Block buffer cache manager with reference counts and LRU recycling.
// ============================================================================
module lru_block_buffer_manager #(
    parameter int BUFFER_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_mode,
    input  logic [lbm_pkg::DEV_W-1:0]     i_device,
    input  logic [lbm_pkg::BLK_W-1:0]     i_block_number,
    input  logic [lbm_pkg::IDX_W-1:0]     i_buffer_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lbm_pkg::IDX_W-1:0]     o_result_index,
    output logic                          o_hit,
    output logic                          o_fill_needed,
    output logic [1:0]                    o_status
);

    lbm_pkg::t_dp_cmd cmd;
    lbm_pkg::t_dp_sts sts;

    lbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lbm_dp #(
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_buffer_index (i_buffer_index),
        .o_result_index (o_result_index),
        .o_hit          (o_hit),
        .o_fill_needed  (o_fill_needed),
        .o_status       (o_status)
    );

`ifndef SYNTHESIS
    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.rd_scan && cmd.rd_sel))
        else $error("two reads issued in one cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("item accepted while not busy afterwards");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || !i_stall))
        else $error("result overwritten before taken");

    a_taken_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !cmd.out_load) |=> !o_valid)
        else $error("result repeated after taken");
`endif

endmodule
